>>> hw/rtl/dwsp_pkg.sv
`timescale 1ns / 1ps
package dwsp_pkg;

   localparam int ENCODER_BITS = 16;
   localparam int SENSOR_BITS  = 12;

   localparam int TARGET_W   = 9;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int DUTY_W     = 16;
   localparam int INTEG_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // speed error covers target minus average count
   localparam int ERR_W     = ((ENCODER_BITS > TARGET_W) ? ENCODER_BITS : TARGET_W) + 1;
   localparam int INT_SUM_W = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
   localparam int DERR_W    = ERR_W + 1;
   localparam int DIFF_W    = ERR_W - 1;
   localparam int DTB_W     = SENSOR_BITS + 1;

   localparam int KP_W  = ERR_W + GAIN_W + 1;
   localparam int KI_W  = INTEG_W + GAIN_W + 1;
   localparam int KD_W  = DERR_W + GAIN_W + 1;
   localparam int BAL_W = DIFF_W + GAIN_W;
   localparam int SKP_W = SENSOR_BITS + GAIN_W;
   localparam int SKD_W = DTB_W + GAIN_W + 1;
   localparam int ACC_W = ((KD_W > SKD_W) ? KD_W : SKD_W) + 4;

   localparam int COUNT_CEIL   = 200;
   localparam int SENSOR_FLOOR = 190;
   localparam int DUTY_MAX     = 65535;

   localparam int RST_TARGET_SPEED   = 30;
   localparam int RST_SPEED_KP       = 2000;
   localparam int RST_SPEED_KI       = 50;
   localparam int RST_SPEED_KD       = 0;
   localparam int RST_BALANCE_KP     = 1800;
   localparam int RST_STEER_KP       = 200;
   localparam int RST_STEER_KD       = 0;
   localparam int RST_INTEGRAL_LIMIT = 2000;

   typedef logic signed [ENCODER_BITS-1:0] enc_type;
   typedef logic        [SENSOR_BITS-1:0]  sense_type;
   typedef logic signed [TARGET_W-1:0]     target_type;
   typedef logic        [GAIN_W-1:0]       gain_type;
   typedef logic        [LIMIT_W-1:0]      limit_type;
   typedef logic        [DUTY_W-1:0]       duty_type;
   typedef logic signed [INTEG_W-1:0]      integ_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_SPEED,
      CSR_SPEED_KP,
      CSR_SPEED_KI,
      CSR_SPEED_KD,
      CSR_BALANCE_KP,
      CSR_STEER_KP,
      CSR_STEER_KD,
      CSR_INTEGRAL_LIMIT
   } csr_index_type;

   // per-tick values handed from the front end to the multiplier stage
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      integ_type                integ;
      logic signed [DERR_W-1:0] derr;
      logic [DIFF_W-1:0]        wdiff;
      logic                     wl_gt;
      sense_type                tb;
      logic signed [DTB_W-1:0]  dtb;
      logic                     vl_gt;
   } front_type;

   function automatic duty_type sat_duty(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] top;
      duty_type                res;
      top = ACC_W'(DUTY_MAX);
      if (v <= 0) begin
         res = '0;
      end else if (v >= top) begin
         res = DUTY_W'(DUTY_MAX);
      end else begin
         res = v[DUTY_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/dwsp_if.sv
`timescale 1ns / 1ps
interface dwsp_req_if;
   import dwsp_pkg::*;
   logic      valid;
   logic      ready;
   enc_type   enc_left;
   enc_type   enc_right;
   sense_type sense_left;
   sense_type sense_right;
   modport source (output valid, enc_left, enc_right, sense_left, sense_right, input ready);
   modport sink   (input valid, enc_left, enc_right, sense_left, sense_right, output ready);
endinterface

interface dwsp_rsp_if;
   import dwsp_pkg::*;
   logic      valid;
   logic      ready;
   duty_type  pwm_left;
   duty_type  pwm_right;
   integ_type integral_now;
   modport source (output valid, pwm_left, pwm_right, integral_now, input ready);
   modport sink   (input valid, pwm_left, pwm_right, integral_now, output ready);
endinterface

interface dwsp_csr_if;
   import dwsp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/dual_wheel_speed_steer_pid_core.sv
`timescale 1ns / 1ps
// Each request passes the input register, integral/state stage, multipliers,
// sums and output register. Throughput: one transaction per cycle while
// rsp.ready does not stall; the integral update closes in one stage.
// Reset: synchronous, active high; gains and limits return to defaults,
// integral and history clear, pipeline empties.
module dual_wheel_speed_steer_pid_core (
   input logic        clock,
   input logic        reset,
   dwsp_req_if.sink   req,
   dwsp_rsp_if.source rsp,
   dwsp_csr_if.sink   csr
);
   import dwsp_pkg::*;

   // configuration
   target_type target_ff;
   gain_type   kp_ff, ki_ff, kd_ff, bal_kp_ff, skp_ff, skd_ff;
   limit_type  limit_ff;

   // loop state
   integ_type               integ_ff;
   logic signed [ERR_W-1:0] prev_err_ff;
   sense_type               prev_tb_ff;

   // stage valids and enables
   logic s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic s0_en, s1_en, s2_en, s3_en, out_en;

   // stage 0: input register
   enc_type   enc_l_ff, enc_r_ff;
   sense_type sen_l_ff, sen_r_ff;

   // stage 1
   front_type front, s1_ff;

   // stage 2: products
   logic signed [KP_W-1:0]  p_kp_ff, p_kp_in;
   logic signed [KI_W-1:0]  p_ki_ff, p_ki_in;
   logic signed [KD_W-1:0]  p_kd_ff, p_kd_in;
   logic        [BAL_W-1:0] p_bal_ff, p_bal_in;
   logic        [SKP_W-1:0] p_skp_ff, p_skp_in;
   logic signed [SKD_W-1:0] p_skd_ff, p_skd_in;
   integ_type               s2_integ_ff;
   logic                    s2_wl_gt_ff, s2_vl_gt_ff;

   // stage 3: drive and correction
   logic signed [ACC_W-1:0] drive_ff, drive_in, corr_ff, corr_in;
   logic signed [ACC_W-1:0] bal_s, turn_s;
   integ_type               s3_integ_ff;

   // output register
   logic signed [ACC_W-1:0] pl_sum, pr_sum;
   duty_type                pwm_l_ff, pwm_r_ff;
   integ_type               out_integ_ff;

   always_comb begin
      out_en = !out_v_ff || rsp.ready;
      s3_en  = !s3_v_ff || out_en;
      s2_en  = !s2_v_ff || s3_en;
      s1_en  = !s1_v_ff || s2_en;
      s0_en  = !s0_v_ff || s1_en;
   end

   assign req.ready = s0_en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_W'(RST_TARGET_SPEED);
         kp_ff     <= GAIN_W'(RST_SPEED_KP);
         ki_ff     <= GAIN_W'(RST_SPEED_KI);
         kd_ff     <= GAIN_W'(RST_SPEED_KD);
         bal_kp_ff <= GAIN_W'(RST_BALANCE_KP);
         skp_ff    <= GAIN_W'(RST_STEER_KP);
         skd_ff    <= GAIN_W'(RST_STEER_KD);
         limit_ff  <= LIMIT_W'(RST_INTEGRAL_LIMIT);
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_TARGET_SPEED:   target_ff <= csr.data[TARGET_W-1:0];
            CSR_SPEED_KP:       kp_ff     <= csr.data[GAIN_W-1:0];
            CSR_SPEED_KI:       ki_ff     <= csr.data[GAIN_W-1:0];
            CSR_SPEED_KD:       kd_ff     <= csr.data[GAIN_W-1:0];
            CSR_BALANCE_KP:     bal_kp_ff <= csr.data[GAIN_W-1:0];
            CSR_STEER_KP:       skp_ff    <= csr.data[GAIN_W-1:0];
            CSR_STEER_KD:       skd_ff    <= csr.data[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: limit_ff  <= csr.data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dwsp_front u_front (
      .enc_left       (enc_l_ff),
      .enc_right      (enc_r_ff),
      .sense_left     (sen_l_ff),
      .sense_right    (sen_r_ff),
      .target_speed   (target_ff),
      .integral_limit (limit_ff),
      .integ          (integ_ff),
      .prev_err       (prev_err_ff),
      .prev_tb        (prev_tb_ff),
      .front          (front)
   );

   always_comb begin
      p_kp_in  = KP_W'(s1_ff.err) * $signed(KP_W'({1'b0, kp_ff}));
      p_ki_in  = KI_W'(s1_ff.integ) * $signed(KI_W'({1'b0, ki_ff}));
      p_kd_in  = KD_W'(s1_ff.derr) * $signed(KD_W'({1'b0, kd_ff}));
      p_bal_in = BAL_W'(s1_ff.wdiff) * BAL_W'(bal_kp_ff);
      p_skp_in = SKP_W'(s1_ff.tb) * SKP_W'(skp_ff);
      p_skd_in = SKD_W'(s1_ff.dtb) * $signed(SKD_W'({1'b0, skd_ff}));
   end

   always_comb begin
      drive_in = ACC_W'(p_kp_ff) + ACC_W'(p_ki_ff) - ACC_W'(p_kd_ff);
      bal_s    = $signed(ACC_W'(p_bal_ff));
      turn_s   = $signed(ACC_W'(p_skp_ff)) - ACC_W'(p_skd_ff);
      corr_in  = (s2_wl_gt_ff ? -bal_s : bal_s) + (s2_vl_gt_ff ? -turn_s : turn_s);
   end

   // left gets +corr, right gets -corr
   always_comb begin
      pl_sum = drive_ff + corr_ff;
      pr_sum = drive_ff - corr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff     <= 1'b0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         integ_ff    <= '0;
         prev_err_ff <= '0;
         prev_tb_ff  <= '0;
      end else begin
         if (s0_en) begin
            s0_v_ff <= req.valid;
         end
         if (s1_en) begin
            s1_v_ff <= s0_v_ff;
         end
         if (s2_en) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_en) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_en) begin
            out_v_ff <= s3_v_ff;
         end
         // loop state advances once per tick, as it leaves stage 0
         if (s0_v_ff && s1_en) begin
            integ_ff    <= front.integ;
            prev_err_ff <= front.err;
            prev_tb_ff  <= front.tb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         enc_l_ff <= req.enc_left;
         enc_r_ff <= req.enc_right;
         sen_l_ff <= req.sense_left;
         sen_r_ff <= req.sense_right;
      end
      if (s1_en) begin
         s1_ff <= front;
      end
      if (s2_en) begin
         p_kp_ff     <= p_kp_in;
         p_ki_ff     <= p_ki_in;
         p_kd_ff     <= p_kd_in;
         p_bal_ff    <= p_bal_in;
         p_skp_ff    <= p_skp_in;
         p_skd_ff    <= p_skd_in;
         s2_integ_ff <= s1_ff.integ;
         s2_wl_gt_ff <= s1_ff.wl_gt;
         s2_vl_gt_ff <= s1_ff.vl_gt;
      end
      if (s3_en) begin
         drive_ff    <= drive_in;
         corr_ff     <= corr_in;
         s3_integ_ff <= s2_integ_ff;
      end
      if (out_en) begin
         pwm_l_ff     <= sat_duty(pl_sum);
         pwm_r_ff     <= sat_duty(pr_sum);
         out_integ_ff <= s3_integ_ff;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.pwm_left     = pwm_l_ff;
   assign rsp.pwm_right    = pwm_r_ff;
   assign rsp.integral_now = out_integ_ff;

endmodule

>>> hw/rtl/dwsp_front.sv
`timescale 1ns / 1ps
module dwsp_front (
   input  dwsp_pkg::enc_type                  enc_left,
   input  dwsp_pkg::enc_type                  enc_right,
   input  dwsp_pkg::sense_type                sense_left,
   input  dwsp_pkg::sense_type                sense_right,
   input  dwsp_pkg::target_type               target_speed,
   input  dwsp_pkg::limit_type                integral_limit,
   input  dwsp_pkg::integ_type                integ,
   input  logic signed [dwsp_pkg::ERR_W-1:0]  prev_err,
   input  dwsp_pkg::sense_type                prev_tb,
   output dwsp_pkg::front_type                front
);
   import dwsp_pkg::*;

   localparam logic signed [ERR_W-1:0] CEIL  = ERR_W'(COUNT_CEIL);
   localparam sense_type               FLOOR = SENSOR_BITS'(SENSOR_FLOOR);

   logic signed [ERR_W-1:0]     sl, sr, sum, sum_adj, avg, tgt, err, wd, wmag;
   logic signed [INT_SUM_W-1:0] isum, lim, icl;
   sense_type                   vl, vr, tb;

   always_comb begin
      sl = {{(ERR_W-ENCODER_BITS){enc_left[ENCODER_BITS-1]}}, enc_left};
      sr = {{(ERR_W-ENCODER_BITS){enc_right[ENCODER_BITS-1]}}, enc_right};
      if (sl > CEIL) begin
         sl = '0;
      end
      if (sr > CEIL) begin
         sr = '0;
      end

      // average truncated toward zero
      sum     = sl + sr;
      sum_adj = sum + $signed(ERR_W'(sum[ERR_W-1]));
      avg     = sum_adj >>> 1;
      tgt     = {{(ERR_W-TARGET_W){target_speed[TARGET_W-1]}}, target_speed};
      err     = tgt - avg;

      isum = {{(INT_SUM_W-INTEG_W){integ[INTEG_W-1]}}, integ}
           + {{(INT_SUM_W-ERR_W){err[ERR_W-1]}}, err};
      lim  = $signed({{(INT_SUM_W-LIMIT_W){1'b0}}, integral_limit});
      if (isum > lim) begin
         icl = lim;
      end else if (isum < -lim) begin
         icl = -lim;
      end else begin
         icl = isum;
      end

      wd   = sl - sr;
      wmag = wd[ERR_W-1] ? -wd : wd;

      vl = (sense_left  <= FLOOR) ? FLOOR : sense_left;
      vr = (sense_right <= FLOOR) ? FLOOR : sense_right;
      tb = (vl > vr) ? (vl - vr) : (vr - vl);

      front.err   = err;
      front.integ = icl[INTEG_W-1:0];
      front.derr  = {err[ERR_W-1], err} - {prev_err[ERR_W-1], prev_err};
      front.wdiff = wmag[DIFF_W-1:0];
      front.wl_gt = (sl > sr);
      front.tb    = tb;
      front.dtb   = $signed({1'b0, tb}) - $signed({1'b0, prev_tb});
      front.vl_gt = (vl > vr);
   end

endmodule
